@@ rtl/core/bzm_pkg.sv @@
`timescale 1ns / 1ps
// bzm_pkg: shared types and constants of the bilinear 2x zoom unit
// no dependencies

package bzm_pkg;

   localparam int CFG_W   = 11;
   localparam int PIX_W   = 8;
   localparam int COORD_W = 11;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 3;

   typedef enum logic {
      CSR_IN_WIDTH  = 1'b0,
      CSR_IN_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_CENTER = 2'd0,
      KIND_UP     = 2'd1,
      KIND_LEFT   = 2'd2,
      KIND_COPY   = 2'd3
   } kind_type;

   // one source pixel, classified and averaged, waiting for the back end
   typedef struct packed {
      logic [COORD_W-1:0] row2;
      logic [COORD_W-1:0] col2;
      logic               has_up;
      logic               has_left;
      logic [PIX_W-1:0]   v_center;
      logic [PIX_W-1:0]   v_up;
      logic [PIX_W-1:0]   v_left;
      logic [PIX_W-1:0]   pix;
      logic               frame_last;
   } job_type;

endpackage

@@ rtl/core/bilinear_zoom_2x_unit.sv @@
`timescale 1ns / 1ps
// bilinear_zoom_2x_unit: 2x bilinear zoom of an 8-bit grey frame
// uses bzm_pkg, bzm_front, bzm_queue, bzm_back
//
//   port group | direction | word
//   req_       | in        | pixel
//   rsp_       | out       | out_row, out_col, value, last_of_run, frame_end
//   csr_       | in        | in_width (index 0), in_height (index 1)
//
// each source pixel gives one to four words, one word per cycle from the back end
// while rsp_stall is low; all words leave through the single rsp_ port
// the front end takes a pixel every cycle while the four-entry job queue has room
// line store read data is registered in the ram, ready in the cycle after the pixel
// reset is synchronous; payload registers and the line store are not cleared
// rsp_stall backs up the job queue and then req_stall

module bilinear_zoom_2x_unit
   import bzm_pkg::*;
#(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [0:0]         csr_index,
   input  logic [CFG_W-1:0]   csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PIX_W-1:0]   req_pixel,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COORD_W-1:0] rsp_out_row,
   output logic [COORD_W-1:0] rsp_out_col,
   output logic [PIX_W-1:0]   rsp_value,
   output logic               rsp_last_of_run,
   output logic               rsp_frame_end
);

   logic    push_valid;
   job_type push_job;
   logic    q_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   bzm_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pixel  (req_pixel),
      .push_valid (push_valid),
      .push_job   (push_job),
      .q_full     (q_full)
   );

   bzm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   bzm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_value       (rsp_value),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

@@ rtl/core/bzm_ram.sv @@
`timescale 1ns / 1ps
// bzm_ram: generic single write port, single read port ram with registered read
// no dependencies

module bzm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bzm_front.sv @@
`timescale 1ns / 1ps
// bzm_front: accepts source pixels, tracks position, reads the line store
// and builds one job word per pixel; uses bzm_pkg and bzm_ram

module bzm_front
   import bzm_pkg::*;
#(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [0:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [PIX_W-1:0] req_pixel,
   output logic             push_valid,
   output job_type          push_job,
   input  logic             q_full
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [PIX_W-1:0] left_ff, left_in;
   logic [PIX_W-1:0] ul_ff, ul_in;

   logic               sb_valid_ff, sb_valid_in;
   logic [COORD_W-1:0] sb_row2_ff, sb_row2_in;
   logic [COORD_W-1:0] sb_col2_ff, sb_col2_in;
   logic               sb_has_up_ff, sb_has_up_in;
   logic               sb_has_left_ff, sb_has_left_in;
   logic [PIX_W-1:0]   sb_pix_ff, sb_pix_in;
   logic [PIX_W-1:0]   sb_left_ff, sb_left_in;
   logic               sb_flast_ff, sb_flast_in;

   logic [31:0]      w_lim, h_lim;
   logic             last_col, last_row;
   logic             accept, sb_move;
   logic [PIX_W-1:0] up_pix;
   logic [9:0]       sum4;
   logic [8:0]       sum_up, sum_left;

   bzm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_COLS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_pixel),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up_pix)
   );

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      if (width_ff == '0) begin
         w_lim = 32'd1;
      end else if (32'(width_ff) > 32'(MAX_COLS)) begin
         w_lim = 32'(MAX_COLS);
      end else begin
         w_lim = 32'(width_ff);
      end
      if (height_ff == '0) begin
         h_lim = 32'd1;
      end else if (32'(height_ff) > 32'(MAX_ROWS)) begin
         h_lim = 32'(MAX_ROWS);
      end else begin
         h_lim = 32'(height_ff);
      end
   end

   assign last_col  = (32'(col_ff) + 32'd1) >= w_lim;
   assign last_row  = (32'(row_ff) + 32'd1) >= h_lim;
   assign req_stall = sb_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign sb_move   = sb_valid_ff && !q_full;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IN_WIDTH:  width_in  = csr_wdata;
            CSR_IN_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      col_in         = col_ff;
      row_in         = row_ff;
      left_in        = left_ff;
      sb_row2_in     = sb_row2_ff;
      sb_col2_in     = sb_col2_ff;
      sb_has_up_in   = sb_has_up_ff;
      sb_has_left_in = sb_has_left_ff;
      sb_pix_in      = sb_pix_ff;
      sb_left_in     = sb_left_ff;
      sb_flast_in    = sb_flast_ff;
      sb_valid_in    = sb_move ? 1'b0 : sb_valid_ff;
      if (accept) begin
         sb_valid_in    = 1'b1;
         sb_row2_in     = COORD_W'({row_ff, 1'b0});
         sb_col2_in     = COORD_W'({col_ff, 1'b0});
         sb_has_up_in   = (row_ff != '0);
         sb_has_left_in = (col_ff != '0);
         sb_pix_in      = req_pixel;
         sb_left_in     = left_ff;
         sb_flast_in    = last_col && last_row;
         left_in        = req_pixel;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign ul_in = sb_move ? up_pix : ul_ff;

   always_comb begin
      sum4     = 10'(ul_ff) + 10'(up_pix) + 10'(sb_left_ff) + 10'(sb_pix_ff) + 10'd2;
      sum_up   = 9'(up_pix) + 9'(sb_pix_ff) + 9'd1;
      sum_left = 9'(sb_left_ff) + 9'(sb_pix_ff) + 9'd1;
   end

   assign push_valid          = sb_move;
   assign push_job.row2       = sb_row2_ff;
   assign push_job.col2       = sb_col2_ff;
   assign push_job.has_up     = sb_has_up_ff;
   assign push_job.has_left   = sb_has_left_ff;
   assign push_job.v_center   = sum4[9:2];
   assign push_job.v_up       = sum_up[8:1];
   assign push_job.v_left     = sum_left[8:1];
   assign push_job.pix        = sb_pix_ff;
   assign push_job.frame_last = sb_flast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CFG_W'(1024);
         height_ff   <= CFG_W'(1024);
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         ul_ff       <= '0;
         sb_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         left_ff     <= left_in;
         ul_ff       <= ul_in;
         sb_valid_ff <= sb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sb_row2_ff     <= sb_row2_in;
      sb_col2_ff     <= sb_col2_in;
      sb_has_up_ff   <= sb_has_up_in;
      sb_has_left_ff <= sb_has_left_in;
      sb_pix_ff      <= sb_pix_in;
      sb_left_ff     <= sb_left_in;
      sb_flast_ff    <= sb_flast_in;
   end

endmodule

@@ rtl/core/bzm_queue.sv @@
`timescale 1ns / 1ps
// bzm_queue: short job queue between front and back end
// uses bzm_pkg

module bzm_queue
   import bzm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

@@ rtl/core/bzm_back.sv @@
`timescale 1ns / 1ps
// bzm_back: expands each job into one to four zoomed pixels, one per cycle while rsp_stall is low
// uses bzm_pkg

module bzm_back
   import bzm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  job_type            head_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COORD_W-1:0] rsp_out_row,
   output logic [COORD_W-1:0] rsp_out_col,
   output logic [PIX_W-1:0]   rsp_value,
   output logic               rsp_last_of_run,
   output logic               rsp_frame_end
);

   logic [2:0]         done_ff, done_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [PIX_W-1:0]   value_ff, value_in;
   logic               last_ff, last_in;
   logic               fend_ff, fend_in;

   kind_type kind;
   logic     load;

   always_comb begin
      if (head_job.has_up && head_job.has_left && !done_ff[0]) begin
         kind = KIND_CENTER;
      end else if (head_job.has_up && !done_ff[1]) begin
         kind = KIND_UP;
      end else if (head_job.has_left && !done_ff[2]) begin
         kind = KIND_LEFT;
      end else begin
         kind = KIND_COPY;
      end
   end

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && (kind == KIND_COPY);

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      fend_in      = fend_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         last_in      = 1'b0;
         fend_in      = 1'b0;
         case (kind)
            KIND_CENTER: begin
               row_in     = head_job.row2 - 1'b1;
               col_in     = head_job.col2 - 1'b1;
               value_in   = head_job.v_center;
               done_in[0] = 1'b1;
            end
            KIND_UP: begin
               row_in     = head_job.row2 - 1'b1;
               col_in     = head_job.col2;
               value_in   = head_job.v_up;
               done_in[1] = 1'b1;
            end
            KIND_LEFT: begin
               row_in     = head_job.row2;
               col_in     = head_job.col2 - 1'b1;
               value_in   = head_job.v_left;
               done_in[2] = 1'b1;
            end
            default: begin
               row_in   = head_job.row2;
               col_in   = head_job.col2;
               value_in = head_job.pix;
               last_in  = 1'b1;
               fend_in  = head_job.frame_last;
               done_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      col_ff   <= col_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      fend_ff  <= fend_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_value       = value_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_frame_end   = fend_ff;

`ifndef SYNTHESIS
   a_fend_on_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && fend_ff |-> last_ff)
      else $error("frame end on a non-copy word");

   a_job_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !last_ff |-> head_valid)
      else $error("job left the queue before its copy word");
`endif

endmodule

@@ verif/bilinear_zoom_2x_unit_test.sv @@
`timescale 1ns / 1ps
// bilinear_zoom_2x_unit_test: self-checking bench for the 2x bilinear zoom unit,
// predicts every zoomed word per accepted pixel and checks the rsp_ stream in order
// depends on bzm_pkg and bilinear_zoom_2x_unit

module bilinear_zoom_2x_unit_test;
   import bzm_pkg::*;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int STUCK_LIMIT = 2000;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   value;
      logic               last_of_run;
      logic               frame_end;
   } zoom_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [0:0]         csr_index = CSR_IN_WIDTH;
   logic [CFG_W-1:0]   csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [PIX_W-1:0]   req_pixel = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [COORD_W-1:0] rsp_out_row;
   logic [COORD_W-1:0] rsp_out_col;
   logic [PIX_W-1:0]   rsp_value;
   logic               rsp_last_of_run;
   logic               rsp_frame_end;

   // zoom model state
   logic [CFG_W-1:0]   zoom_width  = 11'd1024;
   logic [CFG_W-1:0]   zoom_height = 11'd1024;
   logic [PIX_W-1:0]   prev_line [MAX_COLS];
   logic [PIX_W-1:0]   left_px   = '0;
   logic [PIX_W-1:0]   upleft_px = '0;
   int                 src_row   = 0;
   int                 src_col   = 0;
   zoom_word_type      pending_words [$];

   bit                 idle_on      = 1'b1;
   int                 errors       = 0;
   int                 stuck_cycles = 0;
   int                 pixels_sent  = 0;
   int                 pixels_seen  = 0;
   int                 words_seen   = 0;

   bilinear_zoom_2x_unit #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_value      (rsp_value),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_frame_end  (rsp_frame_end)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int eff_dim(input logic [CFG_W-1:0] v, input int max_v);
      if (v == 0) return 1;
      if (int'(v) > max_v) return max_v;
      return int'(v);
   endfunction

   function automatic void push_word(input int r, input int c, input int v,
                                     input logic last, input logic fend);
      zoom_word_type w;
      w.row         = r[COORD_W-1:0];
      w.col         = c[COORD_W-1:0];
      w.value       = v[PIX_W-1:0];
      w.last_of_run = last;
      w.frame_end   = fend;
      pending_words.push_back(w);
   endfunction

   function automatic void zoom_pixel(input logic [PIX_W-1:0] px);
      int   w, h, r, c, up, lf, ul, p;
      logic last_col, last_row;
      w  = eff_dim(zoom_width, MAX_COLS);
      h  = eff_dim(zoom_height, MAX_ROWS);
      r  = src_row;
      c  = src_col;
      p  = px;
      up = prev_line[c];
      lf = left_px;
      ul = upleft_px;
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);
      if (r > 0) begin
         if (c > 0) push_word(2*r - 1, 2*c - 1, (ul + up + lf + p + 2) >> 2, 1'b0, 1'b0);
         push_word(2*r - 1, 2*c, (up + p + 1) >> 1, 1'b0, 1'b0);
      end
      if (c > 0) push_word(2*r, 2*c - 1, (lf + p + 1) >> 1, 1'b0, 1'b0);
      push_word(2*r, 2*c, p, 1'b1, last_col && last_row);
      upleft_px    = up[PIX_W-1:0];
      prev_line[c] = px;
      left_px      = px;
      if (last_col) begin
         src_col = 0;
         src_row = last_row ? 0 : r + 1;
      end else begin
         src_col = c + 1;
      end
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // model update, scoreboard and stall watch
   always @(posedge clock) begin
      zoom_word_type want;
      if (reset) begin
         zoom_width   = 11'd1024;
         zoom_height  = 11'd1024;
         left_px      = '0;
         upleft_px    = '0;
         src_row      = 0;
         src_col      = 0;
         stuck_cycles = 0;
         pending_words.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_IN_WIDTH) zoom_width = csr_wdata;
            else zoom_height = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            zoom_pixel(req_pixel);
            pixels_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            words_seen++;
            if (pending_words.size() == 0) begin
               $display("%0t ns: unexpected word row %0d col %0d value %0d", $time,
                        rsp_out_row, rsp_out_col, rsp_value);
               errors++;
            end else begin
               want = pending_words.pop_front();
               compare_field("out_row", want.row, rsp_out_row);
               compare_field("out_col", want.col, rsp_out_col);
               compare_field("value", want.value, rsp_value);
               compare_field("last_of_run", want.last_of_run, rsp_last_of_run);
               compare_field("frame_end", want.frame_end, rsp_frame_end);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
         else stuck_cycles++;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 15);
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("%0t ns: no handshake for %0d cycles", $time, STUCK_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] px);
      while (idle_on && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   // stop sending and wait until every predicted word has come back
   task automatic drain_words();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] val);
      drain_words();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      int n;
      write_csr(CSR_IN_WIDTH, w);
      write_csr(CSR_IN_HEIGHT, h);
      n = eff_dim(w, MAX_COLS) * eff_dim(h, MAX_ROWS);
      repeat (n) send_pixel(pick_pixel());
   endtask

   // reset dimensions, then width and height shrunk one after the other in mid-frame so the counters wrap
   task automatic test_reset_dims();
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h80);
      write_csr(CSR_IN_WIDTH, 11'd1);
      send_pixel(8'h7F);
      send_pixel(8'hFF);
      write_csr(CSR_IN_HEIGHT, 11'd1);
      send_pixel(8'h01);
   endtask

   // zero registers act as one
   task automatic test_zero_dims();
      write_csr(CSR_IN_WIDTH, 11'd0);
      write_csr(CSR_IN_HEIGHT, 11'd0);
      send_pixel(8'h00);
      send_pixel(8'hFF);
   endtask

   // registers above the maximum act as the maximum
   task automatic test_clamp_dims();
      write_csr(CSR_IN_WIDTH, 11'h7FF);
      write_csr(CSR_IN_HEIGHT, 11'h7FF);
      repeat (4) send_pixel(pick_pixel());
      write_csr(CSR_IN_WIDTH, 11'd2);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      write_csr(CSR_IN_HEIGHT, 11'd2);
      send_pixel(8'hFF);
      send_pixel(8'h00);
   endtask

   task automatic test_extreme_frame();
      logic [PIX_W-1:0] pattern [9] = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                        8'h00, 8'hFF, 8'h01};
      write_csr(CSR_IN_WIDTH, 11'd3);
      write_csr(CSR_IN_HEIGHT, 11'd3);
      foreach (pattern[i]) send_pixel(pattern[i]);
   endtask

   // small random frames, some cut short by shrinking both dimensions to one
   task automatic test_random_frames(input int count);
      int w, h, n, k, start;
      start = pixels_sent;
      while (pixels_sent - start < count) begin
         w = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
         h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
         n = eff_dim(CFG_W'(w), MAX_COLS) * eff_dim(CFG_W'(h), MAX_ROWS);
         if (n > 2 && $urandom_range(7) == 0) begin
            write_csr(CSR_IN_WIDTH, CFG_W'(w));
            write_csr(CSR_IN_HEIGHT, CFG_W'(h));
            k = $urandom_range(1, n - 1);
            repeat (k) send_pixel(pick_pixel());
            write_csr(CSR_IN_WIDTH, 11'd1);
            write_csr(CSR_IN_HEIGHT, 11'd1);
            send_pixel(pick_pixel());
         end else begin
            run_frame(CFG_W'(w), CFG_W'(h));
         end
      end
   endtask

   task automatic test_full_rate();
      drain_words();
      idle_on = 1'b0;
      run_frame(11'd8, 11'd8);
      drain_words();
      idle_on = 1'b1;
   endtask

   task automatic test_pause_drain();
      write_csr(CSR_IN_WIDTH, 11'd5);
      write_csr(CSR_IN_HEIGHT, 11'd4);
      repeat (7) send_pixel(pick_pixel());
      drain_words();
      repeat (13) send_pixel(pick_pixel());
   endtask

   task automatic test_wide_row();
      run_frame(11'd20, 11'd1);
   endtask

   task automatic test_tall_column();
      run_frame(11'd1, 11'd20);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_dims();
      test_zero_dims();
      test_clamp_dims();
      test_extreme_frame();
      test_random_frames(50);
      test_full_rate();
      test_pause_drain();
      test_wide_row();
      test_tall_column();
      drain_words();
      repeat (16) @(posedge clock);
      $display("run covered %0d source pixels and %0d zoomed words", pixels_seen, words_seen);
      $display("small and single-line frames, reset, zero and clamped sizes, mid-frame wrap");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", errors);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ bilinear_zoom_2x_unit.f @@
rtl/core/bzm_pkg.sv
rtl/core/bzm_ram.sv
rtl/core/bzm_front.sv
rtl/core/bzm_queue.sv
rtl/core/bzm_back.sv
rtl/core/bilinear_zoom_2x_unit.sv
verif/bilinear_zoom_2x_unit_test.sv
